// ===== rtl/core/dataset_summary_statistics_defines.svh =====
// Assertion macros shared by the dataset statistics RTL.
// Depends on nothing; included by the top level only.
`ifndef DATASET_SUMMARY_STATISTICS_DEFINES_SVH
`define DATASET_SUMMARY_STATISTICS_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define DSS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dss check failed");

// Next-cycle implication checked outside reset.
`define DSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dss check failed");

`endif

// ===== rtl/core/dss_pkg.sv =====
// Package for the dataset statistics block: widths, defaults, mode codes, states.
// Depends on nothing.
package dss_pkg;

  localparam int DefaultDepth = 256;
  localparam int DefaultSampleBits = 32;
  localparam int ModeW = 2;
  localparam int StatusW = 1;
  localparam int HeldW = 9;
  localparam int OutW = 32;
  localparam int PosW = 8;

  typedef enum logic [ModeW-1:0] {
    MODE_ADD    = 2'd0,
    MODE_REPORT = 2'd1,
    MODE_FIND   = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  // One-hot sequencer states.
  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_SRD    = 9'b000000010,
    ST_SCHK   = 9'b000000100,
    ST_RLO    = 9'b000001000,
    ST_RHI    = 9'b000010000,
    ST_RMID   = 9'b000100000,
    ST_DIV    = 9'b001000000,
    ST_FIND   = 9'b010000000,
    ST_OUT    = 9'b100000000
  } state_t;

endpackage

// ===== rtl/core/dss_ram.sv =====
// Generic single-port RAM with registered read.
// Depends on nothing.
module dss_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Read first: read data registered, returning the old contents on a write.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/core/dataset_summary_statistics.sv =====
// Dataset summary statistics block: collects signed samples, reports statistics.
// Depends on dss_pkg, dss_ram and dataset_summary_statistics_defines.svh.
//
// Usage: an input request carries mode and sample on in_valid/in_stall; one
// result request leaves on out_valid/out_stall with status, held, smallest,
// largest, mean, middle, found and position.
// Mode 0 adds a sample. The arrival entry is written in the first read state
// and the sorted store is shifted by insertion, one moved entry per pass through
// the read and check states, once for each held sample larger than the new one.
// An add to a full set and a report on an empty set go straight to the output state.
// Mode 1 reads three sorted entries and runs a bit-serial divider, one quotient
// bit per cycle. Mode 2 scans the arrival store one entry per cycle.
// Mode 3 clears the count and sum.
// The block takes one request at a time; in_stall is high while a request is
// being worked and while the result waits. The result register holds until
// out_stall is low. Reset empties the set; no clearing pass is needed since
// only entries below the count are ever read.
module dataset_summary_statistics #(
  parameter int DEPTH = dss_pkg::DefaultDepth,
  parameter int SAMPLE_BITS = dss_pkg::DefaultSampleBits
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [dss_pkg::ModeW-1:0]    mode,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [dss_pkg::StatusW-1:0]  status,
  output logic [dss_pkg::HeldW-1:0]    held,
  output logic signed [dss_pkg::OutW-1:0] smallest,
  output logic signed [dss_pkg::OutW-1:0] largest,
  output logic signed [dss_pkg::OutW-1:0] mean,
  output logic signed [dss_pkg::OutW-1:0] middle,
  output logic                         found,
  output logic [dss_pkg::PosW-1:0]     position
);

  import dss_pkg::*;

  `include "dataset_summary_statistics_defines.svh"

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SumW = 64;
  localparam int QW = $clog2(SumW + 1);

  state_t state;
  logic [CW-1:0] fill_count;
  logic [SumW-1:0] running_sum;
  logic signed [SAMPLE_BITS-1:0] value;
  logic [CW-1:0] k;
  logic [CW-1:0] scan;
  logic signed [SAMPLE_BITS-1:0] lo_v;
  logic signed [SAMPLE_BITS-1:0] hi_v;
  logic signed [SAMPLE_BITS-1:0] mid_v;
  logic [SumW-1:0] dividend;
  logic [SumW-1:0] rem;
  logic [QW-1:0] dcount;
  logic neg;

  // Memory ports.
  logic a_we, s_we;
  logic [AW-1:0] a_addr, s_addr;
  logic [SAMPLE_BITS-1:0] a_wdata, s_wdata, a_rdata, s_rdata;

  dss_ram #(.Width(SAMPLE_BITS), .Depth(DEPTH)) u_arrival (
    .clk(clk), .we(a_we), .addr(a_addr), .wdata(a_wdata), .rdata(a_rdata)
  );
  dss_ram #(.Width(SAMPLE_BITS), .Depth(DEPTH)) u_sorted (
    .clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wdata), .rdata(s_rdata)
  );

  logic take;
  logic [CW-1:0] k_m1;
  logic [SumW-1:0] ext_value;
  logic [SumW:0] trial;
  logic [SumW-1:0] mean_mag;

  assign take = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE) || out_valid;
  assign k_m1 = k - CW'(1);
  assign ext_value = SumW'(signed'(value));
  assign trial = {rem, dividend[SumW-1]} - {1'b0, SumW'(fill_count)};
  assign mean_mag = neg ? (SumW'(0) - dividend) : dividend;

  // Memory address and write selection per state.
  always_comb begin
    a_we = 1'b0;
    s_we = 1'b0;
    a_addr = scan[AW-1:0];
    s_addr = k_m1[AW-1:0];
    a_wdata = value;
    s_wdata = value;
    case (state)
      ST_SRD: begin
        a_we = (k == fill_count);
        a_addr = fill_count[AW-1:0];
      end
      ST_SCHK: begin
        if (k != 0 && $signed(value) < $signed(s_rdata)) begin
          s_we = 1'b1;
          s_addr = k[AW-1:0];
          s_wdata = s_rdata;
        end else begin
          s_we = 1'b1;
          s_addr = k[AW-1:0];
        end
      end
      ST_RLO: s_addr = '0;
      ST_RHI: s_addr = AW'(fill_count - CW'(1));
      ST_RMID: s_addr = AW'(fill_count >> 1);
      default: ;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill_count <= '0;
      running_sum <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (take) begin
            value <= sample;
            k <= fill_count;
            scan <= '0;
            status <= '0;
            smallest <= '0;
            largest <= '0;
            mean <= '0;
            middle <= '0;
            found <= 1'b0;
            position <= '0;
            case (mode_t'(mode))
              MODE_ADD: begin
                if (fill_count >= CW'(DEPTH)) begin
                  status <= 1'b1;
                  state <= ST_OUT;
                end else begin
                  state <= ST_SRD;
                end
              end
              MODE_REPORT: state <= (fill_count == 0) ? ST_OUT : ST_RLO;
              MODE_FIND: state <= ST_FIND;
              MODE_CLEAR: begin
                fill_count <= '0;
                running_sum <= '0;
                state <= ST_OUT;
              end
              default: state <= ST_OUT;
            endcase
          end
        end
        // Issue a read of the entry below the insertion point.
        ST_SRD: state <= ST_SCHK;
        // Shift one entry up or drop the new value in place.
        ST_SCHK: begin
          if (k != 0 && $signed(value) < $signed(s_rdata)) begin
            k <= k_m1;
            state <= ST_SRD;
          end else begin
            fill_count <= fill_count + CW'(1);
            running_sum <= running_sum + ext_value;
            state <= ST_OUT;
          end
        end
        ST_RLO: state <= ST_RHI;
        ST_RHI: begin
          lo_v <= s_rdata;
          state <= ST_RMID;
        end
        ST_RMID: begin
          hi_v <= s_rdata;
          neg <= running_sum[SumW-1];
          dividend <= running_sum[SumW-1] ? (SumW'(0) - running_sum) : running_sum;
          rem <= '0;
          dcount <= '0;
          state <= ST_DIV;
        end
        // Restoring division, one quotient bit per cycle.
        ST_DIV: begin
          if (dcount == QW'(0)) begin
            mid_v <= s_rdata;
          end
          if (dcount == QW'(SumW)) begin
            smallest <= OutW'(lo_v);
            largest <= OutW'(hi_v);
            middle <= OutW'(mid_v);
            mean <= OutW'(mean_mag);
            state <= ST_OUT;
          end else begin
            if (!trial[SumW]) begin
              rem <= trial[SumW-1:0];
              dividend <= {dividend[SumW-2:0], 1'b1};
            end else begin
              rem <= {rem[SumW-2:0], dividend[SumW-1]};
              dividend <= {dividend[SumW-2:0], 1'b0};
            end
            dcount <= dcount + QW'(1);
          end
        end
        // Scan: read data for scan-1 arrives while scan advances.
        ST_FIND: begin
          if (scan != 0 && a_rdata == value) begin
            found <= 1'b1;
            position <= PosW'(scan - CW'(1));
            state <= ST_OUT;
          end else if (scan >= fill_count) begin
            state <= ST_OUT;
          end else begin
            scan <= scan + CW'(1);
          end
        end
        ST_OUT: begin
          held <= HeldW'(fill_count);
          out_valid <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // The block never takes a request while a result is pending.
  `DSS_ASSERT_IMP(a_no_take_pending, out_valid, in_stall)
  // Count never exceeds the depth.
  `DSS_ASSERT_IMP(a_fill_bound, 1'b1, fill_count <= CW'(DEPTH))
  // A result is raised only from the output state.
  `DSS_ASSERT_NEXT(a_out_from_state, !out_valid && state != ST_OUT, !out_valid)

endmodule

// ===== verif/tb_dataset_summary_statistics.sv =====
// Testbench for the dataset summary statistics block: directed table, a fill-to-overflow pass, then random requests.
// Depends on dss_pkg and the dataset_summary_statistics RTL.
module tb_dataset_summary_statistics;
  timeunit 1ns;
  timeprecision 1ps;
  import dss_pkg::*;

  localparam int Depth = 256;
  localparam int RandomItems = 1100;
  localparam longint CycleLimit = 3000000;

  typedef struct packed {
    logic [0:0] status;
    logic [8:0] held;
    logic signed [31:0] smallest;
    logic signed [31:0] largest;
    logic signed [31:0] mean;
    logic signed [31:0] middle;
    logic found;
    logic [7:0] position;
  } stats_t;

  typedef struct {
    mode_t mode;
    logic signed [31:0] sample;
    bit typed;
    stats_t want;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic [1:0] mode = MODE_ADD;
  logic signed [31:0] sample = 0;
  logic out_stall = 0;
  logic in_stall, out_valid, found;
  logic [0:0] status;
  logic [8:0] held;
  logic signed [31:0] smallest, largest, mean, middle;
  logic [7:0] position;

  // Shadow of the set held by the block.
  logic signed [31:0] arrivals[Depth];
  logic signed [31:0] ordered[$];
  int fill;
  longint total;

  stats_t pending_results[$];
  int errors = 0;
  longint cycles = 0;
  bit calm = 0;
  bit long_hold = 0;
  int results_seen = 0;

  always #2 clk = ~clk;

  dataset_summary_statistics u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .sample(sample), .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .held(held), .smallest(smallest), .largest(largest),
    .mean(mean), .middle(middle), .found(found), .position(position)
  );

  // Predict the result of one request and update the shadow set.
  function automatic stats_t apply_request(mode_t m, logic signed [31:0] v);
    stats_t r;
    int k;
    longint q;
    r = '{default: 0};
    case (m)
      MODE_ADD: begin
        if (fill >= Depth) begin
          r.status = 1;
        end else begin
          arrivals[fill] = v;
          k = 0;
          while (k < ordered.size() && ordered[k] <= v) k++;
          ordered.insert(k, v);
          fill++;
          total += v;
        end
      end
      MODE_REPORT: begin
        if (fill > 0) begin
          r.smallest = ordered[0];
          r.largest = ordered[fill - 1];
          q = total / fill;
          r.mean = q[31:0];
          r.middle = ordered[fill / 2];
        end
      end
      MODE_FIND: begin
        for (k = 0; k < fill; k++) begin
          if (arrivals[k] == v) begin
            r.found = 1;
            r.position = k[7:0];
            break;
          end
        end
      end
      default: begin
        fill = 0;
        total = 0;
        ordered.delete();
      end
    endcase
    r.held = fill[8:0];
    return r;
  endfunction

  // Drive one request and wait for its acceptance.
  task automatic send_request(mode_t m, logic signed [31:0] v, bit typed, stats_t want);
    stats_t got;
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    mode <= m;
    sample <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = apply_request(m, v);
    if (typed && got != want) begin
      $error("directed row disagrees with predictor for mode %0d", m);
      errors++;
    end
    pending_results.push_back(got);
  endtask

  task automatic drain;
    in_valid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Check each accepted result against the oldest expectation.
  always @(posedge clk) begin
    stats_t e;
    cycles++;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with no request pending");
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (status !== e.status) begin
          $error("status exp %0d got %0d", e.status, status); errors++;
        end
        if (held !== e.held) begin
          $error("held exp %0d got %0d", e.held, held); errors++;
        end
        if (smallest !== e.smallest) begin
          $error("smallest exp %0d got %0d", e.smallest, smallest); errors++;
        end
        if (largest !== e.largest) begin
          $error("largest exp %0d got %0d", e.largest, largest); errors++;
        end
        if (mean !== e.mean) begin
          $error("mean exp %0d got %0d", e.mean, mean); errors++;
        end
        if (middle !== e.middle) begin
          $error("middle exp %0d got %0d", e.middle, middle); errors++;
        end
        if (found !== e.found) begin
          $error("found exp %0d got %0d", e.found, found); errors++;
        end
        if (position !== e.position) begin
          $error("position exp %0d got %0d", e.position, position); errors++;
        end
      end
    end
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver back-pressure: random bursts, one long hold, none when calm.
  initial begin
    int n;
    out_stall <= 0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1;
        repeat (400) @(posedge clk);
        out_stall <= 0;
        long_hold = 0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 7);
        out_stall <= 1;
        repeat (n) @(posedge clk);
        out_stall <= 0;
      end
    end
  end

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $signed(32'($urandom_range(0, 15)) - 32'd8);
      default: return $signed($urandom);
    endcase
  endfunction

  initial begin
    row_t dir[$];
    stats_t z;
    int pick, n;
    mode_t m;
    logic signed [31:0] v;
    z = '{default: 0};
    fill = 0;
    total = 0;
    // Directed rows: empty report, extremes, find hit and miss, clear.
    dir.push_back('{MODE_REPORT, 0, 1, z});
    dir.push_back('{MODE_FIND, 5, 1, z});
    dir.push_back('{MODE_ADD, 32'sh7fff_ffff, 0, z});
    dir.push_back('{MODE_ADD, 32'sh8000_0000, 0, z});
    dir.push_back('{MODE_ADD, -1, 0, z});
    dir.push_back('{MODE_REPORT, 0, 0, z});
    dir.push_back('{MODE_FIND, -1, 0, z});
    dir.push_back('{MODE_FIND, 32'sh8000_0000, 0, z});
    dir.push_back('{MODE_FIND, 77, 0, z});
    dir.push_back('{MODE_ADD, 32'sh8000_0000, 0, z});
    dir.push_back('{MODE_ADD, -7, 0, z});
    dir.push_back('{MODE_REPORT, 0, 0, z});
    dir.push_back('{MODE_CLEAR, 32'sh5555_aaaa, 1, z});
    dir.push_back('{MODE_REPORT, -1, 1, z});
    dir.push_back('{MODE_ADD, -3, 0, z});
    dir.push_back('{MODE_ADD, 2, 0, z});
    dir.push_back('{MODE_REPORT, 0, 0, z});
    dir.push_back('{MODE_CLEAR, 0, 1, z});
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (dir[i]) send_request(dir[i].mode, dir[i].sample, dir[i].typed, dir[i].want);
    drain();
    // Fill the set to the top, overflow it, query it, with a long receiver hold.
    long_hold = 1;
    for (int i = 0; i < Depth + 3; i++) send_request(MODE_ADD, pick_value(), 0, z);
    send_request(MODE_REPORT, 0, 0, z);
    send_request(MODE_FIND, arrivals[Depth - 1], 0, z);
    send_request(MODE_FIND, arrivals[3], 0, z);
    drain();
    send_request(MODE_CLEAR, 0, 0, z);
    // Random mix, mostly adds with interspersed queries and occasional clears.
    for (int i = 0; i < RandomItems; i++) begin
      if (i == RandomItems - 150) calm = 1;
      pick = $urandom_range(0, 99);
      if (pick < 70) m = MODE_ADD;
      else if (pick < 82) m = MODE_REPORT;
      else if (pick < 97) m = MODE_FIND;
      else m = MODE_CLEAR;
      if (m == MODE_FIND && fill > 0 && $urandom_range(0, 1))
        v = arrivals[$urandom_range(0, fill - 1)];
      else
        v = pick_value();
      send_request(m, v, 0, z);
    end
    drain();
    n = 0;
    while (n < 100) begin
      @(posedge clk);
      n++;
    end
    $display("Covered %0d results: empty, full and overflowing sets, extremes, finds, clears.",
             results_seen);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
